@@ rtl/ogd_pkg.sv @@
// occupancy grid denoise: shared types, codes and helpers
// no dependencies; imported by the top level

package ogd_pkg;

    // configuration port
    localparam int CFG_DW    = 9;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_WIDTH  = 1'b0,
        CFG_GRID_HEIGHT = 1'b1
    } cfg_index_t;

    localparam logic [CFG_DW-1:0] GRID_DIM_RESET = 9'd256;

    // survival threshold: more than this many occupied cells in the 3x3 window
    localparam logic [3:0] SURVIVE_MIN = 4'd2;

    typedef enum logic [1:0] {
        ACT_INSERT  = 2'd0,
        ACT_QUERY   = 2'd1,
        ACT_CLEAR   = 2'd2,
        ACT_DENOISE = 2'd3
    } action_t;

    typedef struct packed {
        action_t    action;
        logic [7:0] cell_x;
        logic [7:0] cell_y;
    } ogd_in_t;

    typedef struct packed {
        logic occupied;
        logic status;
    } ogd_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_SWEEP,
        ST_FILTER,
        ST_DONE
    } state_t;

    // filter phases per window column: three scratch reads, then evaluate
    localparam logic [1:0] PH_ROW_ABOVE = 2'd0;
    localparam logic [1:0] PH_ROW_MID   = 2'd1;
    localparam logic [1:0] PH_ROW_BELOW = 2'd2;
    localparam logic [1:0] PH_EVAL      = 2'd3;

    function automatic logic [1:0] ones3(input logic [2:0] b);
        return {1'b0, b[0]} + {1'b0, b[1]} + {1'b0, b[2]};
    endfunction

endpackage

@@ rtl/ogd_ram.sv @@
// occupancy grid denoise: generic single-write, single-read synchronous ram
// registered read, read-first on a same-address write; no dependencies

module ogd_ram #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 65536,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/occupancy_grid_denoise_top.sv @@
// occupancy grid denoise: top level, control sequencer and grid memories
// depends on ogd_pkg and ogd_ram

// channel   | direction | handshake         | payload
// ----------+-----------+-------------------+-----------------------------------
// s_        | in        | s_valid / s_ready | ogd_in_t  {action, cell_x, cell_y}
// m_        | out       | m_valid / m_ready | ogd_out_t {occupied, status}
// cfg_      | in        | cfg_we            | cfg_index, cfg_wdata
//
// insert and query: one occupancy read, then write-back and result
// clear: a clearing sweep over all MAX_HEIGHT * 2**clog2(MAX_WIDTH) occupancy
//   entries, one entry a cycle, then the result
// denoise: the same sweep copies the grid into scratch while clearing it, then
//   filtering walks each row over width + 1 window columns (three scratch reads
//   per window column), skipped for a zero width or height, then the result
// reset and any register write start the clearing sweep; s_ready stays low
//   until it ends. a full result register keeps a finished item waiting in
//   the done state, with s_ready low until its result moves

module occupancy_grid_denoise_top #(
    parameter int unsigned MAX_WIDTH  = 256,
    parameter int unsigned MAX_HEIGHT = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [ogd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ogd_pkg::CFG_DW-1:0]    cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  ogd_pkg::ogd_in_t              s_payload,
    output logic                          m_valid,
    input  logic                          m_ready,
    output ogd_pkg::ogd_out_t             m_payload
);

    import ogd_pkg::*;

    // address is {row, column}; row stride is a power of two
    localparam int unsigned XW    = $clog2(MAX_WIDTH);
    localparam int unsigned YW    = $clog2(MAX_HEIGHT);
    localparam int unsigned XCW   = $clog2(MAX_WIDTH + 1);
    localparam int unsigned YCW   = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned AW    = XW + YW;
    localparam int unsigned DEPTH = MAX_HEIGHT * (2 ** XW);
    localparam int unsigned EWW   = (XCW > CFG_DW) ? XCW : CFG_DW;
    localparam int unsigned EHW   = (YCW > CFG_DW) ? YCW : CFG_DW;
    localparam int unsigned IXW   = (XCW > 8) ? XCW : 8;
    localparam int unsigned IYW   = (YCW > 8) ? YCW : 8;

    state_t state_reg, state_next;

    // configuration
    logic [CFG_DW-1:0] grid_w_reg, grid_h_reg;
    logic [XCW-1:0]    eff_w;
    logic [YCW-1:0]    eff_h;

    // current item
    action_t        act_reg;
    logic           in_grid_reg;
    logic [AW-1:0]  addr_reg;
    logic           res_occ_reg, res_status_reg;

    // sweep
    logic [AW-1:0]  sweep_reg;
    logic           copy_reg;
    logic           pend_reg;
    logic           sweep_last;

    // filter walk
    logic [YW-1:0]  row_reg;
    logic [XCW-1:0] col_reg;
    logic [1:0]     phase_reg;
    logic           rd_ok_reg;
    logic [1:0]     colbits_reg;
    logic [2:0]     left_reg, mid_reg;

    // scratch write pipeline during the copy sweep
    logic           scr_we_reg;
    logic [AW-1:0]  scr_waddr_reg;

    // output register
    logic           m_valid_reg;
    ogd_out_t       m_payload_reg;

    // memory ports
    logic           occ_we, occ_wdata, occ_rdata;
    logic [AW-1:0]  occ_waddr, occ_raddr;
    logic [AW-1:0]  scr_raddr;
    logic           scr_rdata;

    // misc combinational
    logic           accept;
    logic           out_free;
    logic           in_grid;
    logic [AW-1:0]  in_addr;
    logic           acc_occ, acc_status;
    logic           load_acc, load_done;
    logic [YW:0]    rd_row_ext;
    logic           rd_ok;
    logic           col_last, row_last;
    logic [YCW-1:0] row_inc;
    logic [XCW-1:0] col_m1;
    logic [2:0]     newcol;
    logic [3:0]     win_count;
    logic           eval, survive;
    logic           filter_skip;

    // register values above the maximum saturate
    assign eff_w = (EWW'(grid_w_reg) > EWW'(MAX_WIDTH)) ? XCW'(MAX_WIDTH) : XCW'(grid_w_reg);
    assign eff_h = (EHW'(grid_h_reg) > EHW'(MAX_HEIGHT)) ? YCW'(MAX_HEIGHT) : YCW'(grid_h_reg);

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign in_grid  = (IXW'(s_payload.cell_x) < IXW'(eff_w)) &&
                      (IYW'(s_payload.cell_y) < IYW'(eff_h));
    assign in_addr  = {YW'(s_payload.cell_y), XW'(s_payload.cell_x)};

    // read-back result of insert or query
    assign acc_occ    = (act_reg == ACT_QUERY) && in_grid_reg && occ_rdata;
    assign acc_status = ((act_reg == ACT_QUERY) || (act_reg == ACT_INSERT)) && !in_grid_reg;

    assign sweep_last  = (sweep_reg == AW'(DEPTH - 1));
    assign filter_skip = (eff_w == '0) || (eff_h == '0);

    // filter window: issue row is row - 1 + phase; wraps above row 0 and is masked
    assign rd_row_ext = {1'b0, row_reg} + (YW + 1)'(phase_reg) - (YW + 1)'(1);
    assign rd_ok      = (rd_row_ext < (YW + 1)'(eff_h)) && (col_reg < eff_w);
    assign scr_raddr  = {rd_row_ext[YW-1:0], col_reg[XW-1:0]};
    assign col_last   = (col_reg == eff_w);
    assign row_inc    = YCW'(row_reg) + YCW'(1);
    assign row_last   = (row_inc == eff_h);
    assign col_m1     = col_reg - XCW'(1);

    // bit 0 row above, bit 1 own row, bit 2 row below
    assign newcol    = {scr_rdata && rd_ok_reg, colbits_reg};
    assign win_count = 4'(ones3(left_reg)) + 4'(ones3(mid_reg)) + 4'(ones3(newcol));
    assign eval      = (state_reg == ST_FILTER) && (phase_reg == PH_EVAL) && (col_reg != '0);
    assign survive   = mid_reg[1] && (win_count > SURVIVE_MIN);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if ((s_payload.action == ACT_INSERT) || (s_payload.action == ACT_QUERY)) begin
                        state_next = ST_ACCESS;
                    end else begin
                        state_next = ST_SWEEP;
                    end
                end
            end
            ST_ACCESS: begin
                state_next = out_free ? ST_IDLE : ST_DONE;
            end
            ST_SWEEP: begin
                if (sweep_last) begin
                    if (copy_reg) begin
                        state_next = filter_skip ? ST_DONE : ST_FILTER;
                    end else begin
                        state_next = pend_reg ? ST_DONE : ST_IDLE;
                    end
                end
            end
            ST_FILTER: begin
                if ((phase_reg == PH_EVAL) && col_last && row_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        // a new geometry starts empty
        if (cfg_we) begin
            state_next = ST_SWEEP;
        end
    end

    // outputs and memory controls
    always_comb begin
        s_ready   = 1'b0;
        occ_raddr = in_addr;
        occ_we    = 1'b0;
        occ_waddr = addr_reg;
        occ_wdata = 1'b1;
        load_acc  = 1'b0;
        load_done = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_ACCESS: begin
                occ_we   = (act_reg == ACT_INSERT) && in_grid_reg;
                load_acc = out_free;
            end
            ST_SWEEP: begin
                // clear each entry while reading its old value for the copy
                occ_raddr = sweep_reg;
                occ_we    = 1'b1;
                occ_waddr = sweep_reg;
                occ_wdata = 1'b0;
            end
            ST_FILTER: begin
                occ_we    = eval && survive;
                occ_waddr = {row_reg, XW'(col_m1)};
            end
            ST_DONE: begin
                load_done = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_SWEEP;
            grid_w_reg  <= GRID_DIM_RESET;
            grid_h_reg  <= GRID_DIM_RESET;
            sweep_reg   <= '0;
            copy_reg    <= 1'b0;
            pend_reg    <= 1'b0;
            scr_we_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            scr_we_reg <= (state_reg == ST_SWEEP) && copy_reg;

            if (cfg_we) begin
                case (cfg_index_t'(cfg_index))
                    CFG_GRID_WIDTH:  grid_w_reg <= cfg_wdata;
                    CFG_GRID_HEIGHT: grid_h_reg <= cfg_wdata;
                    default:         grid_w_reg <= grid_w_reg;
                endcase
                sweep_reg <= '0;
                copy_reg  <= 1'b0;
                pend_reg  <= 1'b0;
            end else if (accept && ((s_payload.action == ACT_CLEAR) ||
                                    (s_payload.action == ACT_DENOISE))) begin
                sweep_reg <= '0;
                copy_reg  <= (s_payload.action == ACT_DENOISE);
                pend_reg  <= 1'b1;
            end else if (state_reg == ST_SWEEP) begin
                sweep_reg <= sweep_reg + AW'(1);
            end

            if (load_acc || load_done) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        scr_waddr_reg <= sweep_reg;

        if (accept) begin
            act_reg        <= s_payload.action;
            in_grid_reg    <= in_grid;
            addr_reg       <= in_addr;
            res_occ_reg    <= 1'b0;
            res_status_reg <= 1'b0;
        end

        if (state_reg == ST_ACCESS) begin
            res_occ_reg    <= acc_occ;
            res_status_reg <= acc_status;
        end

        if (load_acc) begin
            m_payload_reg.occupied <= acc_occ;
            m_payload_reg.status   <= acc_status;
        end else if (load_done) begin
            m_payload_reg.occupied <= res_occ_reg;
            m_payload_reg.status   <= res_status_reg;
        end

        // filter walk over rows, window column by window column, through the read and evaluate phases
        if (state_reg == ST_SWEEP) begin
            row_reg   <= '0;
            col_reg   <= '0;
            phase_reg <= PH_ROW_ABOVE;
            left_reg  <= '0;
            mid_reg   <= '0;
        end else if (state_reg == ST_FILTER) begin
            rd_ok_reg <= rd_ok;
            phase_reg <= phase_reg + 2'd1;
            if ((phase_reg == PH_ROW_MID) || (phase_reg == PH_ROW_BELOW)) begin
                colbits_reg <= {scr_rdata && rd_ok_reg, colbits_reg[1]};
            end
            if (phase_reg == PH_EVAL) begin
                if (col_last) begin
                    col_reg  <= '0;
                    row_reg  <= row_reg + YW'(1);
                    left_reg <= '0;
                    mid_reg  <= '0;
                end else begin
                    col_reg  <= col_reg + XCW'(1);
                    left_reg <= mid_reg;
                    mid_reg  <= newcol;
                end
            end
        end
    end

    ogd_ram #(
        .WIDTH(1),
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_occ_ram (
        .aclk (aclk),
        .we   (occ_we),
        .waddr(occ_waddr),
        .wdata(occ_wdata),
        .raddr(occ_raddr),
        .rdata(occ_rdata)
    );

    // snapshot of the grid for the filter pass
    ogd_ram #(
        .WIDTH(1),
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_scr_ram (
        .aclk (aclk),
        .we   (scr_we_reg),
        .waddr(scr_waddr_reg),
        .wdata(occ_rdata),
        .raddr(scr_raddr),
        .rdata(scr_rdata)
    );

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

@@ dv/tb_occupancy_grid_denoise_top.sv @@
`timescale 1ns / 1ps
// testbench for occupancy_grid_denoise_top: a directed stimulus table, then four random
// phases of insert/query traffic with clear and denoise passes, checked against a grid model
// depends on ogd_pkg and the rtl of occupancy_grid_denoise_top

module tb_occupancy_grid_denoise_top;
    import ogd_pkg::*;

    localparam int unsigned MAX_W      = 256;
    localparam int unsigned MAX_H      = 256;
    localparam int unsigned N_CELLS    = MAX_W * MAX_H;
    localparam int unsigned KEEP_ABOVE = 2;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned TAIL_CYCLES     = 16;
    localparam int          PHASE_ITEMS     = 295;
    // slowest legal run: about 23 clearing sweeps plus short filter walks,
    // and ~1200 transfers stretched by gaps and stalls; taken ~4x over
    localparam longint unsigned CYCLE_LIMIT = 64'd6_000_000;

    typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

    // one line of the directed table: a register write or an item, with a hand-typed
    // answer where it is obvious, otherwise the grid model decides
    typedef struct {
        row_kind_t         kind;
        cfg_index_t        reg_sel;
        logic [CFG_DW-1:0] reg_val;
        ogd_in_t           item;
        bit                typed;
        ogd_out_t          answer;
    } stim_row_t;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DW-1:0] cfg_wdata;
    logic              s_valid;
    logic              s_ready;
    ogd_in_t           s_payload;
    logic              m_valid;
    logic              m_ready;
    ogd_out_t          m_payload;

    // grid model state
    bit                model_occ  [N_CELLS];
    bit                model_snap [N_CELLS];
    logic [CFG_DW-1:0] model_cols_reg;
    logic [CFG_DW-1:0] model_rows_reg;

    // answers owed by the block, oldest first
    ogd_out_t          pending_answers [$];
    stim_row_t         directed_rows [$];

    int                mismatches    = 0;
    int                src_idle_pct  = 0;
    int                snk_stall_pct = 0;
    int                hold_requests = 0;
    longint unsigned   cycle_count   = 0;

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    occupancy_grid_denoise_top #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // ---------------------------------------------------------------- grid model

    // register values above the maximum saturate
    function automatic int unsigned active_cols();
        return (model_cols_reg > MAX_W) ? MAX_W : int'(model_cols_reg);
    endfunction

    function automatic int unsigned active_rows();
        return (model_rows_reg > MAX_H) ? MAX_H : int'(model_rows_reg);
    endfunction

    function automatic void model_wipe();
        foreach (model_occ[i]) model_occ[i] = 1'b0;
    endfunction

    // snapshot the grid, empty it, then keep each marked cell whose clipped 3x3 window
    // (the cell included) holds more than KEEP_ABOVE marked cells of the snapshot
    function automatic void model_denoise();
        int unsigned w, h, cnt, x_lo, x_hi, y_lo, y_hi;
        w = active_cols();
        h = active_rows();
        foreach (model_occ[i]) begin
            model_snap[i] = model_occ[i];
            model_occ[i]  = 1'b0;
        end
        for (int unsigned y = 0; y < h; y++) begin
            for (int unsigned x = 0; x < w; x++) begin
                if (!model_snap[y * MAX_W + x]) continue;
                x_lo = (x > 0) ? x - 1 : 0;
                x_hi = (x + 1 < w) ? x + 1 : w - 1;
                y_lo = (y > 0) ? y - 1 : 0;
                y_hi = (y + 1 < h) ? y + 1 : h - 1;
                cnt  = 0;
                for (int unsigned n = y_lo; n <= y_hi; n++)
                    for (int unsigned m = x_lo; m <= x_hi; m++)
                        cnt += model_snap[n * MAX_W + m];
                if (cnt > KEEP_ABOVE) model_occ[y * MAX_W + x] = 1'b1;
            end
        end
    endfunction

    // applies one item to the model and returns the answer it owes
    function automatic ogd_out_t grid_step(ogd_in_t it);
        ogd_out_t    res;
        bit          in_grid;
        int unsigned idx;
        res     = '0;
        in_grid = (it.cell_x < active_cols()) && (it.cell_y < active_rows());
        idx     = it.cell_y * MAX_W + it.cell_x;
        case (it.action)
            ACT_INSERT: begin
                if (in_grid) model_occ[idx] = 1'b1;
                else res.status = 1'b1;
            end
            ACT_QUERY: begin
                if (in_grid) res.occupied = model_occ[idx];
                else res.status = 1'b1;
            end
            ACT_CLEAR: model_wipe();
            default:   model_denoise();
        endcase
        return res;
    endfunction

    // ---------------------------------------------------------------- directed table

    function automatic void add_item(action_t act, logic [7:0] x, logic [7:0] y);
        stim_row_t row;
        row = '{kind: ROW_ITEM, reg_sel: CFG_GRID_WIDTH, reg_val: '0,
                item: '{act, x, y}, typed: 1'b0, answer: '0};
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic void add_checked(action_t act, logic [7:0] x, logic [7:0] y,
                                        logic occ, logic st);
        stim_row_t row;
        row = '{kind: ROW_ITEM, reg_sel: CFG_GRID_WIDTH, reg_val: '0,
                item: '{act, x, y}, typed: 1'b1, answer: '{occ, st}};
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic void add_reg(cfg_index_t sel, logic [CFG_DW-1:0] val);
        stim_row_t row;
        row = '{kind: ROW_CFG, reg_sel: sel, reg_val: val,
                item: '0, typed: 1'b0, answer: '0};
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic void build_directed();
        // freshly reset 256 x 256 grid: empty, far corner usable
        add_checked(ACT_QUERY,  8'd0,   8'd0,   1'b0, 1'b0);
        add_checked(ACT_QUERY,  8'd255, 8'd255, 1'b0, 1'b0);
        add_checked(ACT_INSERT, 8'd255, 8'd255, 1'b0, 1'b0);
        add_checked(ACT_QUERY,  8'd255, 8'd255, 1'b1, 1'b0);
        // marking an already marked cell is fine
        add_checked(ACT_INSERT, 8'd255, 8'd255, 1'b0, 1'b0);
        add_item(ACT_QUERY,  8'd254, 8'd255);
        add_item(ACT_INSERT, 8'd0,   8'd0);
        // clear ignores its coordinates
        add_checked(ACT_CLEAR,  8'd200, 8'd13,  1'b0, 1'b0);
        add_item(ACT_QUERY,  8'd255, 8'd255);
        // narrow grid, height above the maximum saturates
        add_reg(CFG_GRID_WIDTH,  9'd3);
        add_reg(CFG_GRID_HEIGHT, 9'd511);
        add_checked(ACT_INSERT, 8'd3,   8'd0,   1'b0, 1'b1);
        add_checked(ACT_QUERY,  8'd3,   8'd255, 1'b0, 1'b1);
        add_item(ACT_QUERY,  8'd2,   8'd255);
        // an l-shaped cluster survives, the pair at the bottom edge does not
        add_item(ACT_INSERT, 8'd0,   8'd0);
        add_item(ACT_INSERT, 8'd1,   8'd0);
        add_item(ACT_INSERT, 8'd1,   8'd1);
        add_item(ACT_INSERT, 8'd2,   8'd255);
        add_item(ACT_INSERT, 8'd2,   8'd254);
        add_checked(ACT_DENOISE, 8'd7,  8'd9,   1'b0, 1'b0);
        add_item(ACT_QUERY,  8'd1,   8'd1);
        add_item(ACT_QUERY,  8'd2,   8'd255);
        add_item(ACT_QUERY,  8'd0,   8'd1);
        // zero width: nothing is inside
        add_reg(CFG_GRID_WIDTH,  9'd0);
        add_checked(ACT_INSERT, 8'd0,   8'd0,   1'b0, 1'b1);
        add_checked(ACT_QUERY,  8'd0,   8'd0,   1'b0, 1'b1);
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic drop_valid();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_answers.size() != 0) @(posedge aclk);
    endtask

    // register writes also empty the grid in the block and in the model
    task automatic write_reg(cfg_index_t sel, logic [CFG_DW-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        if (sel == CFG_GRID_WIDTH) model_cols_reg = val;
        else model_rows_reg = val;
        model_wipe();
    endtask

    // offers one item after a random gap, holds it until the transfer, then books
    // the answer: the typed one where given, the model's otherwise
    task automatic send_item(ogd_in_t it, bit typed, ogd_out_t answer);
        ogd_out_t predicted;
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_payload <= it;
        do @(posedge aclk); while (!s_ready);
        predicted = grid_step(it);
        pending_answers.insert(pending_answers.size(), typed ? answer : predicted);
    endtask

    // one random phase: new geometry, then mostly inserts and queries packed into a
    // small hot box so clusters form, some anywhere in the grid, some anywhere at all
    task automatic run_phase(logic [CFG_DW-1:0] cols, logic [CFG_DW-1:0] rows,
                             int src_pct, int snk_pct,
                             bit with_hold, bit with_pause, bit with_clear);
        int unsigned box_x, box_y, box_w, box_h, r;
        ogd_in_t     it;
        drop_valid();
        wait_drained();
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        write_reg(CFG_GRID_WIDTH,  cols);
        write_reg(CFG_GRID_HEIGHT, rows);
        box_w = (active_cols() < 10) ? active_cols() : 10;
        box_h = (active_rows() < 10) ? active_rows() : 10;
        box_x = $urandom_range(active_cols() - box_w);
        box_y = $urandom_range(active_rows() - box_h);
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            it.cell_x = 8'($urandom_range(255));
            it.cell_y = 8'($urandom_range(255));
            if (i == PHASE_ITEMS / 2 || i == PHASE_ITEMS * 9 / 10) begin
                it.action = ACT_DENOISE;
                // let the block run dry before the last pass
                if (with_pause && i == PHASE_ITEMS * 9 / 10) begin
                    drop_valid();
                    wait_drained();
                end
            end else if (with_clear && i == PHASE_ITEMS * 7 / 10) begin
                it.action = ACT_CLEAR;
            end else begin
                it.action = $urandom_range(1) ? ACT_QUERY : ACT_INSERT;
                r = $urandom_range(99);
                if (r < 70) begin
                    it.cell_x = 8'(box_x + $urandom_range(box_w - 1));
                    it.cell_y = 8'(box_y + $urandom_range(box_h - 1));
                end else if (r < 85) begin
                    it.cell_x = 8'($urandom_range(active_cols() - 1));
                    it.cell_y = 8'($urandom_range(active_rows() - 1));
                end
            end
            // long receiver hold-off while items keep coming
            if (with_hold && i == PHASE_ITEMS / 4) hold_requests++;
            send_item(it, 1'b0, '0);
        end
    endtask

    // ---------------------------------------------------------------- result side

    // m_ready changes at the falling edge; a hold-off request holds it low until the
    // hold-off counter runs out, otherwise it stalls at the phase's rate
    initial begin : result_sink
        int unsigned hold_left;
        int          hold_served;
        hold_left   = 0;
        hold_served = 0;
        m_ready     = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_requests != hold_served) begin
                hold_served++;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= (snk_stall_pct == 0) || ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    // every result transfer is matched against the oldest booked answer
    always @(posedge aclk) begin : answer_check
        ogd_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_answers.size() == 0) begin
                $error("result transfer with no answer pending: occupied %0d status %0d",
                       m_payload.occupied, m_payload.status);
                mismatches++;
            end else begin
                want = pending_answers.pop_front();
                if (m_payload.occupied !== want.occupied) begin
                    $error("occupied: expected %0d, got %0d", want.occupied,
                           m_payload.occupied);
                    mismatches++;
                end
                if (m_payload.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_payload.status);
                    mismatches++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("occupancy_grid_denoise_top regression: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin : stimulus
        stim_row_t row;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_GRID_WIDTH;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_payload = '0;
        model_cols_reg = GRID_DIM_RESET;
        model_rows_reg = GRID_DIM_RESET;
        model_wipe();
        build_directed();

        repeat (11) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // directed table; register writes only once the block has answered everything
        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            if (row.kind == ROW_CFG) begin
                drop_valid();
                wait_drained();
                write_reg(row.reg_sel, row.reg_val);
            end else begin
                send_item(row.item, row.typed, row.answer);
            end
        end

        // random phases: no idling, sender idle, receiver stalling, both lightly
        run_phase(9'd511, 9'd8, 0, 0, 1'b1, 1'b0, 1'b0);
        run_phase(9'd5, 9'd300, 59, 0, 1'b0, 1'b1, 1'b0);
        run_phase(9'd1, 9'($urandom_range(20, 40)), 0, 59, 1'b0, 1'b0, 1'b1);
        run_phase(9'($urandom_range(2, 40)), 9'($urandom_range(2, 40)), 9, 9,
                  1'b0, 1'b0, 1'b0);

        drop_valid();
        wait_drained();
        // a quiet tail to catch any stray result
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_answers.size() == 0) begin
            $display("occupancy_grid_denoise_top regression: pass");
        end else begin
            $display("occupancy_grid_denoise_top regression: fail");
        end
        $finish;
    end

endmodule
